FILE: rtl/two_wire_handshake_byte_link_core_assert.svh
// Assertion macros for the byte link core.
`ifndef TWO_WIRE_HANDSHAKE_BYTE_LINK_CORE_ASSERT_SVH
`define TWO_WIRE_HANDSHAKE_BYTE_LINK_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define TWHBL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TWHBL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TWHBL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define TWHBL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/twhbl_pkg.sv
`default_nettype none

package twhbl_pkg;

  localparam int DEF_TIMER_WIDTH = 16;
  localparam int CFG_WIDTH       = 16;
  localparam int IN_DATA_W       = 16;
  localparam int OUT_DATA_W      = 16;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 32;

  localparam logic [CFG_WIDTH-1:0] TIMEOUT_RST = 16'd1000;
  localparam logic [CFG_WIDTH-1:0] GAP_RST     = 16'd0;

  localparam logic [1:0] OP_PLAIN = 2'd0;
  localparam logic [1:0] OP_SEND  = 2'd1;
  localparam logic [1:0] OP_RECV  = 2'd2;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_WRITE_TO = 2'd1;
  localparam logic [1:0] ERR_READ_TO  = 2'd2;

  localparam logic REG_TIMEOUT = 1'b0;
  localparam logic REG_GAP     = 1'b1;

  typedef struct packed {
    logic       cmd_tx;
    logic       cmd_rx;
    logic [7:0] tx_byte;
    logic       red;
    logic       white;
  } item_t;

  typedef struct packed {
    logic       rejected;
    logic [1:0] error_code;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       done;
    logic       busy;
    logic       white_drive;
    logic       red_drive;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/twhbl_front.sv
`default_nettype none

module twhbl_front (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  // [1:0] operation, [9:2] tx_byte, [10] red_in, [11] white_in, [15:12] zero
  input  wire  [twhbl_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                 q_valid,
  output twhbl_pkg::item_t                     q_item,
  input  wire                                  q_pop
);

  twhbl_pkg::item_t ent_r [2];
  logic [1:0]       count_r;
  logic             wr_r;
  logic             rd_r;
  logic             push;
  twhbl_pkg::item_t cls;

  assign in_tready = (count_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != 2'd0);
  assign q_item    = ent_r[rd_r];

  always_comb begin
    cls.cmd_tx  = (in_tdata[1:0] == twhbl_pkg::OP_SEND);
    cls.cmd_rx  = (in_tdata[1:0] == twhbl_pkg::OP_RECV);
    cls.tx_byte = in_tdata[9:2];
    cls.red     = in_tdata[10];
    cls.white   = in_tdata[11];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
      wr_r    <= 1'b0;
      rd_r    <= 1'b0;
    end else begin
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (q_pop) begin
        rd_r <= ~rd_r;
      end
      case ({push, q_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/twhbl_engine.sv
`default_nettype none

module twhbl_engine #(
  parameter int TIMER_WIDTH = twhbl_pkg::DEF_TIMER_WIDTH
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire  [twhbl_pkg::CFG_WIDTH-1:0]      timeout_ticks,
  input  wire  [twhbl_pkg::CFG_WIDTH-1:0]      bit_gap_ticks,
  input  wire                                  q_valid,
  input  wire  twhbl_pkg::item_t               q_item,
  output logic                                 q_pop,
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  // [0] red_drive, [1] white_drive, [2] busy_res, [3] done_res, [4] rx_valid,
  // [12:5] rx_byte, [14:13] error_code, [15] rejected
  output logic [twhbl_pkg::OUT_DATA_W-1:0]     out_tdata
);

  `include "two_wire_handshake_byte_link_core_assert.svh"

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_TX_PULL = 3'd1;
  localparam logic [2:0] PH_TX_REL  = 3'd2;
  localparam logic [2:0] PH_RX_WAIT = 3'd3;
  localparam logic [2:0] PH_RX_ACK  = 3'd4;
  localparam logic [2:0] PH_GAP     = 3'd5;

  localparam logic [1:0] DRV_REL        = 2'b11;
  localparam logic [1:0] DRV_PULL_WHITE = 2'b10;
  localparam logic [1:0] DRV_PULL_RED   = 2'b01;

  localparam logic [31:0] TMAX = 32'hFFFF_FFFF >> (32 - TIMER_WIDTH);

  logic [2:0]             phase_r, phase_nxt;
  logic                   is_rx_r, is_rx_nxt;
  logic [7:0]             shift_r, shift_nxt;
  logic [3:0]             bits_r, bits_nxt;
  logic [TIMER_WIDTH-1:0] wait_r, wait_nxt;
  logic [TIMER_WIDTH-1:0] gap_r, gap_nxt;
  logic                   cur_r, cur_nxt;
  logic [1:0]             drive_r, drive_nxt;

  logic                   out_valid_r;
  twhbl_pkg::res_t        res_r;
  twhbl_pkg::res_t        res_nxt;

  logic [31:0]            tmo32, gap32, tlim32, glim32;
  logic [TIMER_WIDTH-1:0] tlim, glim;
  logic [TIMER_WIDTH:0]   wait_inc, gap_inc;
  logic                   t_expired, g_expired;
  logic                   done, rxv, line_lvl;
  logic [1:0]             err;

  assign tmo32     = {16'd0, timeout_ticks};
  assign gap32     = {16'd0, bit_gap_ticks};
  assign tlim32    = (tmo32 > TMAX) ? TMAX : tmo32;
  assign glim32    = (gap32 > TMAX) ? TMAX : gap32;
  assign tlim      = tlim32[TIMER_WIDTH-1:0];
  assign glim      = glim32[TIMER_WIDTH-1:0];
  assign wait_inc  = {1'b0, wait_r} + {{TIMER_WIDTH{1'b0}}, 1'b1};
  assign gap_inc   = {1'b0, gap_r} + {{TIMER_WIDTH{1'b0}}, 1'b1};
  assign t_expired = (wait_inc >= {1'b0, tlim});
  assign g_expired = (gap_inc >= {1'b0, glim});

  assign q_pop      = q_valid && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r;

  always_comb begin
    phase_nxt = phase_r;
    is_rx_nxt = is_rx_r;
    shift_nxt = shift_r;
    bits_nxt  = bits_r;
    wait_nxt  = wait_r;
    gap_nxt   = gap_r;
    cur_nxt   = cur_r;
    drive_nxt = drive_r;
    done      = 1'b0;
    rxv       = 1'b0;
    err       = twhbl_pkg::ERR_OK;
    line_lvl  = 1'b0;
    res_nxt   = '0;

    if (phase_r == PH_IDLE) begin
      if (q_item.cmd_tx) begin
        is_rx_nxt = 1'b0;
        shift_nxt = q_item.tx_byte;
        bits_nxt  = 4'd0;
        cur_nxt   = q_item.tx_byte[0];
        drive_nxt = q_item.tx_byte[0] ? DRV_PULL_WHITE : DRV_PULL_RED;
        phase_nxt = PH_TX_PULL;
        wait_nxt  = '0;
      end else if (q_item.cmd_rx) begin
        is_rx_nxt = 1'b1;
        shift_nxt = 8'd0;
        bits_nxt  = 4'd0;
        phase_nxt = PH_RX_WAIT;
        wait_nxt  = '0;
      end
    end else begin
      res_nxt.rejected = q_item.cmd_tx || q_item.cmd_rx;
      case (phase_r)
        PH_TX_PULL, PH_TX_REL: begin
          line_lvl = cur_r ? q_item.red : q_item.white;
          if ((phase_r == PH_TX_PULL) ? !line_lvl : line_lvl) begin
            if (phase_r == PH_TX_PULL) begin
              drive_nxt = DRV_REL;
              phase_nxt = PH_TX_REL;
              wait_nxt  = '0;
            end else begin
              shift_nxt = {1'b0, shift_r[7:1]};
              bits_nxt  = bits_r + 4'd1;
              phase_nxt = PH_GAP;
              gap_nxt   = '0;
            end
          end else if (t_expired) begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
            err       = twhbl_pkg::ERR_WRITE_TO;
          end else begin
            wait_nxt = wait_inc[TIMER_WIDTH-1:0];
          end
        end
        PH_RX_WAIT: begin
          if (!(q_item.red && q_item.white)) begin
            cur_nxt   = q_item.red && !q_item.white;
            shift_nxt = {cur_nxt, shift_r[7:1]};
            drive_nxt = cur_nxt ? DRV_PULL_RED : DRV_PULL_WHITE;
            phase_nxt = PH_RX_ACK;
            wait_nxt  = '0;
          end else if (t_expired) begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
            err       = twhbl_pkg::ERR_READ_TO;
          end else begin
            wait_nxt = wait_inc[TIMER_WIDTH-1:0];
          end
        end
        PH_RX_ACK: begin
          if (cur_r ? q_item.white : q_item.red) begin
            drive_nxt = DRV_REL;
            bits_nxt  = bits_r + 4'd1;
            phase_nxt = PH_GAP;
            gap_nxt   = '0;
          end else if (t_expired) begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
            err       = twhbl_pkg::ERR_WRITE_TO;
          end else begin
            wait_nxt = wait_inc[TIMER_WIDTH-1:0];
          end
        end
        PH_GAP: begin
          if (!g_expired) begin
            gap_nxt = gap_inc[TIMER_WIDTH-1:0];
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase

      // end of bit with no gap, or gap elapsed: move on to the next bit, or finish after the eighth
      if ((phase_nxt == PH_GAP && phase_r != PH_GAP && glim == '0) ||
          (phase_r == PH_GAP && g_expired)) begin
        if (bits_nxt >= 4'd8) begin
          phase_nxt = PH_IDLE;
          done      = 1'b1;
          err       = twhbl_pkg::ERR_OK;
        end else if (is_rx_r) begin
          phase_nxt = PH_RX_WAIT;
          wait_nxt  = '0;
        end else begin
          cur_nxt   = shift_nxt[0];
          drive_nxt = shift_nxt[0] ? DRV_PULL_WHITE : DRV_PULL_RED;
          phase_nxt = PH_TX_PULL;
          wait_nxt  = '0;
        end
      end
      rxv = done && (err == twhbl_pkg::ERR_OK) && is_rx_r;
    end

    res_nxt.red_drive   = drive_nxt[1];
    res_nxt.white_drive = drive_nxt[0];
    res_nxt.busy        = (phase_nxt != PH_IDLE);
    res_nxt.done        = done;
    res_nxt.rx_valid    = rxv;
    res_nxt.rx_byte     = rxv ? shift_nxt : 8'd0;
    res_nxt.error_code  = err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      is_rx_r     <= 1'b0;
      shift_r     <= 8'd0;
      bits_r      <= 4'd0;
      wait_r      <= '0;
      gap_r       <= '0;
      cur_r       <= 1'b0;
      drive_r     <= DRV_REL;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r <= phase_nxt;
        is_rx_r <= is_rx_nxt;
        shift_r <= shift_nxt;
        bits_r  <= bits_nxt;
        wait_r  <= wait_nxt;
        gap_r   <= gap_nxt;
        cur_r   <= cur_nxt;
        drive_r <= drive_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

  `TWHBL_ASSERT_IMPL(a_done_not_busy, clk, rst_n, out_valid_r && res_r.done, !res_r.busy)
  `TWHBL_ASSERT_IMPL(a_rxv_ok, clk, rst_n, out_valid_r && res_r.rx_valid, res_r.done && res_r.error_code == twhbl_pkg::ERR_OK)
  `TWHBL_ASSERT_IMPL(a_err_done, clk, rst_n, out_valid_r && res_r.error_code != twhbl_pkg::ERR_OK, res_r.done)
  `TWHBL_ASSERT_IMPL(a_bits_range, clk, rst_n, phase_r != PH_IDLE, bits_r <= 4'd8)
  `TWHBL_ASSERT_NEXT(a_idle_hold, clk, rst_n, q_pop && phase_r == PH_IDLE && !q_item.cmd_tx && !q_item.cmd_rx, phase_r == PH_IDLE && $stable(drive_r))

endmodule

`default_nettype wire

FILE: rtl/two_wire_handshake_byte_link_core.sv
// Two-wire open-drain byte link engine.
// in_* : one transaction per clock tick with the sampled red and white line
//        levels and an optional send or receive command.
// out_*: one result transaction per input transaction, in order: line drive,
//        busy, done and error pulses, received byte, rejected command flag.
// cfg_*: APB-style write/read of timeout_ticks (0x0) and bit_gap_ticks (0x4).
//        Write only while no transfer is in progress.
// Throughput: one transaction per cycle while the receiver takes results. A
// two-entry input queue feeds the protocol state machine, which updates once
// per cycle into a result register when it pops an item. An accepted input
// is stored in a queue entry, then the state machine writes its result register.
// Receiver stall: the result register holds, the queue fills its two entries
// and in_tready drops; no transaction is lost.
// Reset (rst_n low, synchronous): state machine idle, both lines released,
// queue and result register empty, registers at 1000 and 0 ticks.
`default_nettype none

module two_wire_handshake_byte_link_core #(
  parameter int TIMER_WIDTH = twhbl_pkg::DEF_TIMER_WIDTH
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  // [1:0] operation, [9:2] tx_byte, [10] red_in, [11] white_in, [15:12] zero
  input  wire  [twhbl_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  // [0] red_drive, [1] white_drive, [2] busy_res, [3] done_res, [4] rx_valid,
  // [12:5] rx_byte, [14:13] error_code, [15] rejected
  output logic [twhbl_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  wire                                  cfg_psel,
  input  wire                                  cfg_penable,
  input  wire                                  cfg_pwrite,
  input  wire  [twhbl_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire  [twhbl_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [twhbl_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                 cfg_pready
);

  logic [twhbl_pkg::CFG_WIDTH-1:0] timeout_r;
  logic [twhbl_pkg::CFG_WIDTH-1:0] gap_r;
  logic                            cfg_wr;
  logic                            q_valid;
  logic                            q_pop;
  twhbl_pkg::item_t                q_item;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_paddr[2])
      twhbl_pkg::REG_TIMEOUT: cfg_prdata = {16'd0, timeout_r};
      twhbl_pkg::REG_GAP:     cfg_prdata = {16'd0, gap_r};
      default:                cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= twhbl_pkg::TIMEOUT_RST;
      gap_r     <= twhbl_pkg::GAP_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == twhbl_pkg::REG_TIMEOUT) begin
        timeout_r <= cfg_pwdata[twhbl_pkg::CFG_WIDTH-1:0];
      end else begin
        gap_r <= cfg_pwdata[twhbl_pkg::CFG_WIDTH-1:0];
      end
    end
  end

  twhbl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  twhbl_engine #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .timeout_ticks (timeout_r),
    .bit_gap_ticks (gap_r),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata)
  );

endmodule

`default_nettype wire
